// ----- rtl/core/utge_pkg.sv -----
package utge_pkg;

  localparam int DEFAULT_MAX_INPUTS  = 4;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam int OP_W    = 2;
  localparam int PORT_W  = 2;
  localparam int TIDX_W  = 8;
  localparam int WORD_W  = 6;
  localparam int LVL_W   = 2;
  localparam int COUNT_W = 3;
  localparam int CFG_W   = 3;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_EVENT = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  localparam logic [LVL_W-1:0] LVL_Z = 2'd2;
  localparam logic [LVL_W-1:0] LVL_X = 2'd3;

  localparam logic [0:0] CFG_INPUT_COUNT = 1'b0;
  localparam logic [0:0] CFG_SEQUENTIAL  = 1'b1;

  typedef enum logic [1:0] {
    ITEM_NONE,
    ITEM_WRITE,
    ITEM_EVENT,
    ITEM_INIT
  } kind_t;

  // One classified word on its way from the front to the back. The level
  // field holds the new input value or the init output, Z already mapped to X.
  typedef struct packed {
    kind_t             kind;
    logic [PORT_W-1:0] port;
    logic [TIDX_W-1:0] table_index;
    logic [WORD_W-1:0] table_word;
    logic [LVL_W-1:0]  level;
  } item_t;

  function automatic int pow3(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 3;
    end
    return r;
  endfunction

  // Base-3 digit of a logic level: 0, 1, or 2 for anything unknown.
  function automatic logic [1:0] digit(input logic [LVL_W-1:0] lvl);
    return lvl[1] ? 2'd2 : lvl;
  endfunction

  function automatic logic [LVL_W-1:0] z_to_x(input logic [LVL_W-1:0] lvl);
    return (lvl == LVL_Z) ? LVL_X : lvl;
  endfunction

endpackage

// ----- rtl/core/udp_table_gate_evaluator.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     op, port, table_index, table_word,
//                                              new_value, init_output
// out       output     out_valid / out_stall   out_value
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low. An event's result passes
// through the queue, the registered table word and the registered out_value.
// Synchronous reset clears inputs and output to unknown and the index to 2; the
// truth table holds whatever it held until written.
// A stalled output holds the result stage, the queue of QUEUE_DEPTH words then
// fills and in_stall rises.
module udp_table_gate_evaluator #(
  parameter int MAX_INPUTS  = utge_pkg::DEFAULT_MAX_INPUTS,
  parameter int QUEUE_DEPTH = utge_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utge_pkg::OP_W-1:0]     op,
  input  logic [utge_pkg::PORT_W-1:0]   port,
  input  logic [utge_pkg::TIDX_W-1:0]   table_index,
  input  logic [utge_pkg::WORD_W-1:0]   table_word,
  input  logic [utge_pkg::LVL_W-1:0]    new_value,
  input  logic [utge_pkg::LVL_W-1:0]    init_output,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utge_pkg::LVL_W-1:0]    out_value,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [utge_pkg::CFG_W-1:0]    cfg_data
);

  localparam int NW = $clog2(MAX_INPUTS + 1);

  logic [utge_pkg::COUNT_W-1:0] input_count;
  logic                         sequential;
  logic [NW-1:0]                n_eff;

  utge_pkg::item_t front_item;
  utge_pkg::item_t q_head;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count <= utge_pkg::COUNT_W'(1);
      sequential  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        utge_pkg::CFG_INPUT_COUNT: input_count <= cfg_data[utge_pkg::COUNT_W-1:0];
        utge_pkg::CFG_SEQUENTIAL:  sequential  <= cfg_data[0];
      endcase
    end
  end

  // A count of zero acts as one input, a count above the maximum as the maximum.
  always_comb begin
    if (input_count == '0) begin
      n_eff = NW'(1);
    end else if (int'(input_count) > MAX_INPUTS) begin
      n_eff = NW'(MAX_INPUTS);
    end else begin
      n_eff = NW'(input_count);
    end
  end

  assign in_stall = q_full;

  utge_front #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_front (
    .op          (op),
    .port        (port),
    .table_index (table_index),
    .table_word  (table_word),
    .new_value   (new_value),
    .init_output (init_output),
    .n_eff       (n_eff),
    .item        (front_item)
  );

  utge_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  utge_back #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .sequential (sequential),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value)
  );

endmodule

// ----- rtl/core/utge_front.sv -----
module utge_front #(
  parameter int MAX_INPUTS = utge_pkg::DEFAULT_MAX_INPUTS
) (
  input  logic [utge_pkg::OP_W-1:0]         op,
  input  logic [utge_pkg::PORT_W-1:0]       port,
  input  logic [utge_pkg::TIDX_W-1:0]       table_index,
  input  logic [utge_pkg::WORD_W-1:0]       table_word,
  input  logic [utge_pkg::LVL_W-1:0]        new_value,
  input  logic [utge_pkg::LVL_W-1:0]        init_output,
  input  logic [$clog2(MAX_INPUTS+1)-1:0]   n_eff,
  output utge_pkg::item_t                   item
);

  localparam int ENTRIES = utge_pkg::pow3(MAX_INPUTS + 1);

  always_comb begin
    item.port        = port;
    item.table_index = table_index;
    item.table_word  = table_word;
    item.level       = utge_pkg::z_to_x(new_value);
    unique case (op)
      utge_pkg::OP_WRITE: begin
        if (int'(port) < MAX_INPUTS && int'(table_index) < ENTRIES) begin
          item.kind = utge_pkg::ITEM_WRITE;
        end else begin
          item.kind = utge_pkg::ITEM_NONE;
        end
      end
      utge_pkg::OP_EVENT: begin
        // Events on ports beyond the active input count are dropped here.
        if (int'(port) < int'(n_eff)) begin
          item.kind = utge_pkg::ITEM_EVENT;
        end else begin
          item.kind = utge_pkg::ITEM_NONE;
        end
      end
      utge_pkg::OP_INIT: begin
        item.kind  = utge_pkg::ITEM_INIT;
        item.level = utge_pkg::z_to_x(init_output);
      end
      default: begin
        item.kind = utge_pkg::ITEM_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/core/utge_queue.sv -----
module utge_queue #(
  parameter int DEPTH = utge_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utge_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output utge_pkg::item_t head
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);

  utge_pkg::item_t slots [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/core/utge_back.sv -----
module utge_back #(
  parameter int MAX_INPUTS = utge_pkg::DEFAULT_MAX_INPUTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_INPUTS+1)-1:0]   n_eff,
  input  logic                              sequential,
  input  logic                              q_empty,
  input  utge_pkg::item_t                   q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [utge_pkg::LVL_W-1:0]        out_value
);

  localparam int ENTRIES = utge_pkg::pow3(MAX_INPUTS + 1);
  localparam int IDXW    = $clog2(ENTRIES);
  localparam int SW      = IDXW + 2;
  localparam int NW      = $clog2(MAX_INPUTS + 1);
  localparam int PW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  // Digit weights 3^i for every digit position of the state index.
  logic [IDXW-1:0] wt [MAX_INPUTS+1];
  for (genvar i = 0; i <= MAX_INPUTS; i++) begin : g_wt
    assign wt[i] = IDXW'(utge_pkg::pow3(i));
  end

  function automatic logic [SW-1:0] dmul(input logic [1:0] d, input logic [IDXW-1:0] w);
    unique case (d)
      2'd0:    return '0;
      2'd1:    return SW'(w);
      default: return SW'(w) << 1;
    endcase
  endfunction

  // Brings a value in (-ENTRIES, 2*ENTRIES) back into the index range.
  function automatic logic [IDXW-1:0] norm(input logic [SW-1:0] v);
    if (v[SW-1]) begin
      return IDXW'(v + SW'(ENTRIES));
    end else if (v >= SW'(ENTRIES)) begin
      return IDXW'(v - SW'(ENTRIES));
    end else begin
      return IDXW'(v);
    end
  endfunction

  logic [utge_pkg::WORD_W-1:0] table_mem [MAX_INPUTS][ENTRIES];

  logic [utge_pkg::LVL_W-1:0] input_levels [MAX_INPUTS];
  logic [utge_pkg::LVL_W-1:0] output_level;
  logic [utge_pkg::LVL_W-1:0] output_level_next;
  logic [IDXW-1:0]            index;
  logic [IDXW-1:0]            index_next;

  // Issue stage: the head of the queue.
  logic [PW-1:0]              row;
  logic [utge_pkg::LVL_W-1:0] ov;
  logic                       a_change;
  logic                       a_init;
  logic [IDXW-1:0]            wn;
  logic [IDXW-1:0]            wp;
  logic [SW-1:0]              delta;
  logic [IDXW-1:0]            u;
  logic [IDXW-1:0]            init_idx;

  // Result stage: one table word read for a changing event.
  logic                       b_valid;
  logic [1:0]                 b_sel;
  logic [utge_pkg::WORD_W-1:0] rdata;
  logic [utge_pkg::LVL_W-1:0] outn;
  logic                       b_result;
  logic                       b_done;
  logic                       b_accept;
  logic [2:0]                 kidx;
  logic [SW-1:0]              koff;

  assign row      = PW'(q_head.port);
  assign ov       = input_levels[row];
  assign a_change = (q_head.kind == utge_pkg::ITEM_EVENT) && (ov != q_head.level);
  assign a_init   = (q_head.kind == utge_pkg::ITEM_INIT);
  assign wn       = wt[n_eff];
  assign wp       = wt[NW'(row)];

  always_comb begin
    unique case (b_sel)
      2'd0:    outn = rdata[1:0];
      2'd1:    outn = rdata[3:2];
      default: outn = rdata[5:4];
    endcase
  end

  assign b_result = (outn != output_level);
  assign b_done   = b_valid && (!b_result || !out_valid || !out_stall);
  assign b_accept = !b_valid || b_done;
  assign q_pop    = !q_empty && b_accept;

  assign delta = dmul(utge_pkg::digit(q_head.level), wp) - dmul(utge_pkg::digit(ov), wp);
  assign u     = (q_pop && a_change) ? norm(SW'(index) + delta) : index;

  // All inputs unknown gives 3^n - 1; in sequential mode the output digit sits above them.
  assign init_idx = IDXW'(SW'(wn) - SW'(1)
                    + (sequential ? dmul(utge_pkg::digit(q_head.level), wn) : SW'(0)));

  // The output digit move of the finishing event is folded into the index
  // that the next event reads, so events can follow each other every cycle while the output does not stall.
  always_comb begin
    if (b_done && b_result && sequential) begin
      kidx = 3'd2 + {1'b0, utge_pkg::digit(outn)} - {1'b0, utge_pkg::digit(output_level)};
    end else begin
      kidx = 3'd2;
    end
    unique case (kidx)
      3'd0:    koff = '0 - (SW'(wn) << 1);
      3'd1:    koff = '0 - SW'(wn);
      3'd3:    koff = SW'(wn);
      3'd4:    koff = SW'(wn) << 1;
      default: koff = '0;
    endcase
    if (q_pop && a_init) begin
      index_next = init_idx;
    end else begin
      index_next = norm(SW'(u) + koff);
    end
  end

  always_comb begin
    if (q_pop && a_init) begin
      output_level_next = q_head.level;
    end else if (b_done && b_result) begin
      output_level_next = outn;
    end else begin
      output_level_next = output_level;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == utge_pkg::ITEM_WRITE) begin
      table_mem[row][IDXW'(q_head.table_index)] <= q_head.table_word;
    end
    if (q_pop && a_change) begin
      rdata <= table_mem[row][index_next];
      b_sel <= utge_pkg::digit(ov);
    end
    if (b_done && b_result) begin
      out_value <= outn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
        input_levels[i] <= utge_pkg::LVL_X;
      end
      output_level <= utge_pkg::LVL_X;
      index        <= IDXW'(2);
      b_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop && a_init) begin
        for (int i = 0; i < MAX_INPUTS; i++) begin
          input_levels[i] <= utge_pkg::LVL_X;
        end
      end else if (q_pop && a_change) begin
        input_levels[row] <= q_head.level;
      end
      output_level <= output_level_next;
      index        <= index_next;
      if (b_accept) begin
        b_valid <= q_pop && a_change;
      end
      if (b_done && b_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    index < IDXW'(ENTRIES))
    else $error("state index out of range");

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_done |=> b_valid && $stable(rdata) && $stable(b_sel))
    else $error("pending table word lost while the output is stalled");

  a_result_changes: assert property (@(posedge clk) disable iff (rst)
    b_done && b_result |=> out_valid && out_value != $past(output_level))
    else $error("result does not change the gate output");

  // A table word may hold 2 as an output, but an input level never stays Z.
  a_no_z_level: assert property (@(posedge clk) disable iff (rst)
    input_levels[0] != utge_pkg::LVL_Z)
    else $error("high impedance stored as an input level");

endmodule
